>>> rtl/ccd_pkg.sv
`default_nettype none
package ccd_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W = 32;
	localparam int ROOT_W = 32;
	localparam int SQ_W = 2 * ROOT_W;
	localparam int CFG_IDX_W = 3;
	localparam logic [30:0] EDGE_INV_RESET = 31'd13107;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIUS_BOTTOM = 3'd0,
		CFG_RADIUS_TOP    = 3'd1,
		CFG_HALF_HEIGHT   = 3'd2,
		CFG_EDGE_DX       = 3'd3,
		CFG_EDGE_DY       = 3'd4,
		CFG_EDGE_INV      = 3'd5
	} cfg_idx_t;
endpackage
`default_nettype wire

>>> rtl/ccd_isqrt.sv
`default_nettype none
module ccd_isqrt #(
	parameter int SIDE_W = 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic [ccd_pkg::SQ_W-1:0]   in_val,
	input  wire logic [SIDE_W-1:0]          in_side,
	output logic                            out_valid,
	output logic [ccd_pkg::ROOT_W-1:0]      out_root,
	output logic [SIDE_W-1:0]               out_side
);
	localparam int RW = ccd_pkg::ROOT_W;
	localparam int VW = ccd_pkg::SQ_W;

	logic          vld_s  [RW];
	logic [RW:0]   rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [VW-1:0] val_s  [RW];
	logic [SIDE_W-1:0] side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic          src_vld;
		logic [RW:0]   src_rem;
		logic [RW-1:0] src_root;
		logic [VW-1:0] src_val;
		logic [SIDE_W-1:0] src_side;
		logic [RW+2:0] rem_n;
		logic [RW+2:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign src_vld  = in_valid;
			assign src_rem  = '0;
			assign src_root = '0;
			assign src_val  = in_val;
			assign src_side = in_side;
		end else begin : g_rest
			assign src_vld  = vld_s[k-1];
			assign src_rem  = rem_s[k-1];
			assign src_root = root_s[k-1];
			assign src_val  = val_s[k-1];
			assign src_side = side_s[k-1];
		end

		assign rem_n = {src_rem, src_val[VW-1:VW-2]};
		assign trial = {1'b0, src_root, 2'b01};
		assign ge    = rem_n >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (RW+1)'(rem_n - trial) : rem_n[RW:0];
				root_s[k] <= {src_root[RW-2:0], ge};
				val_s[k]  <= {src_val[VW-3:0], 2'b00};
				side_s[k] <= src_side;
			end
		end
	end

	assign out_valid = vld_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_side  = side_s[RW-1];
endmodule
`default_nettype wire

>>> rtl/capped_cone_distance_top.sv
// Throughput: one word per cycle unless the output stalls; the two 32-stage
// square-root pipelines, one stage per root bit, set the latency.
// A stall at the output holds every stage at once.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the
// configuration registers with their default cone.
`default_nettype none
module capped_cone_distance_top #(
	parameter int FRAC_BITS = ccd_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ccd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ccd_pkg::WORD_W-1:0]      cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [31:0]              point_x,
	input  wire logic signed [31:0]              point_y,
	input  wire logic signed [31:0]              point_z,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [31:0]                   distance
);
	localparam int F = FRAC_BITS;

	logic signed [31:0] r1_q, r2_q, h_q, dx_q, dy_q;
	logic [30:0]        inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r1_q  <= 32'd1 << F;
			r2_q  <= '0;
			h_q   <= 32'd1 << F;
			dx_q  <= 32'd0 - (32'd1 << F);
			dy_q  <= 32'd2 << F;
			inv_q <= ccd_pkg::EDGE_INV_RESET;
		end else if (cfg_we) begin
			unique case (ccd_pkg::cfg_idx_t'(cfg_index))
				ccd_pkg::CFG_RADIUS_BOTTOM: r1_q  <= cfg_data;
				ccd_pkg::CFG_RADIUS_TOP:    r2_q  <= cfg_data;
				ccd_pkg::CFG_HALF_HEIGHT:   h_q   <= cfg_data;
				ccd_pkg::CFG_EDGE_DX:       dx_q  <= cfg_data;
				ccd_pkg::CFG_EDGE_DY:       dy_q  <= cfg_data;
				ccd_pkg::CFG_EDGE_INV:      inv_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? 32'd0 - v : v;
	endfunction

	function automatic logic [31:0] lim_mag(input logic signed [35:0] v);
		logic [35:0] m;
		m = v[35] ? 36'd0 - v : v;
		return (m > 36'h080000000) ? 32'h80000000 : m[31:0];
	endfunction

	logic en;
	logic out_valid_q;
	logic signed [31:0] dist_q;
	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	// squares of x and z
	logic v_s1, v_s2;
	logic [63:0] sqx_s1, sqz_s1, sum_s2;
	logic [31:0] y_s1, y_s2;

	// after radial root
	logic        qa_valid;
	logic [31:0] qa_root, qa_y;

	logic v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	logic [31:0] q_s3, q_s4, q_s5, q_s6, q_s7, q_s8, q_s9;
	logic signed [31:0] y_s3, y_s4, y_s5, y_s6, y_s7, y_s8, y_s9;
	logic signed [33:0] cax_s3, cax_s4, cax_s5, cax_s6, cax_s7, cax_s8, cax_s9, cax_s10;
	logic signed [33:0] cay_s3, cay_s4, cay_s5, cay_s6, cay_s7, cay_s8, cay_s9, cay_s10;
	logic signed [33:0] dq_s3;
	logic signed [32:0] dh_s3;
	logic signed [65:0] pdx_s4;
	logic signed [64:0] pdy_s4;
	logic signed [66:0] d_s5;
	logic        dpos_s6, dpos_s7;
	logic [63:0] pl_s6;
	logic [62:0] ph_s6;
	logic [95:0] prod_s7;
	logic [F:0]  t_s8;
	logic signed [F+33:0] tdx_s9, tdy_s9;
	logic signed [35:0] cbx_s10, cby_s10;
	logic [63:0] sa_s11, sb_s11, sc_s11, sd_s11;
	logic        neg_s11, neg_s12, neg_s13;
	logic [63:0] dca_s12, dcb_s12, dmin_s13;

	logic        rb_valid;
	logic [31:0] rb_root;
	logic        rb_neg;

	logic [31:0] uy_c;
	logic signed [31:0] ya_c, rsel_c;
	logic signed [F+33:0] fdx_c, fdy_c;

	assign ya_c   = qa_y;
	assign uy_c   = mag32(qa_y);
	assign rsel_c = ya_c[31] ? r1_q : r2_q;
	assign fdx_c  = tdx_s9 >>> F;
	assign fdy_c  = tdy_s9 >>> F;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1;
			v_s3 <= qa_valid; v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			v_s8 <= v_s7; v_s9 <= v_s8; v_s10 <= v_s9; v_s11 <= v_s10; v_s12 <= v_s11;
			v_s13 <= v_s12;
			out_valid_q <= rb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= mag32(point_x) * mag32(point_x);
			sqz_s1 <= mag32(point_z) * mag32(point_z);
			y_s1   <= point_y;
			sum_s2 <= sqx_s1 + sqz_s1;
			y_s2   <= y_s1;

			q_s3   <= qa_root;
			y_s3   <= ya_c;
			cax_s3 <= ($signed({2'b00, qa_root}) < $signed({{2{rsel_c[31]}}, rsel_c})) ? '0 :
				$signed({2'b00, qa_root}) - $signed({{2{rsel_c[31]}}, rsel_c});
			cay_s3 <= $signed({2'b00, uy_c}) - $signed({{2{h_q[31]}}, h_q});
			dq_s3  <= $signed({{2{r2_q[31]}}, r2_q}) - $signed({2'b00, qa_root});
			dh_s3  <= $signed({h_q[31], h_q}) - $signed({ya_c[31], ya_c});

			pdx_s4 <= dq_s3 * dx_q;
			pdy_s4 <= dh_s3 * dy_q;
			q_s4 <= q_s3; y_s4 <= y_s3; cax_s4 <= cax_s3; cay_s4 <= cay_s3;

			d_s5 <= $signed({pdx_s4[65], pdx_s4}) + $signed({{2{pdy_s4[64]}}, pdy_s4});
			q_s5 <= q_s4; y_s5 <= y_s4; cax_s5 <= cax_s4; cay_s5 <= cay_s4;

			dpos_s6 <= !d_s5[66] && (d_s5 != '0);
			pl_s6   <= d_s5[32:0] * inv_q;
			ph_s6   <= d_s5[64:33] * inv_q;
			q_s6 <= q_s5; y_s6 <= y_s5; cax_s6 <= cax_s5; cay_s6 <= cay_s5;

			prod_s7 <= {ph_s6, 33'd0} + {32'd0, pl_s6};
			dpos_s7 <= dpos_s6;
			q_s7 <= q_s6; y_s7 <= y_s6; cax_s7 <= cax_s6; cay_s7 <= cay_s6;

			t_s8 <= !dpos_s7 ? '0 :
				(|prod_s7[95:3*F]) ? {1'b1, {F{1'b0}}} : {1'b0, prod_s7[3*F-1:2*F]};
			q_s8 <= q_s7; y_s8 <= y_s7; cax_s8 <= cax_s7; cay_s8 <= cay_s7;

			tdx_s9 <= $signed({1'b0, t_s8}) * dx_q;
			tdy_s9 <= $signed({1'b0, t_s8}) * dy_q;
			q_s9 <= q_s8; y_s9 <= y_s8; cax_s9 <= cax_s8; cay_s9 <= cay_s8;

			cbx_s10 <= $signed({4'd0, q_s9}) - $signed({{4{r2_q[31]}}, r2_q})
				+ $signed({{2{fdx_c[33]}}, fdx_c[33:0]});
			cby_s10 <= $signed({{4{y_s9[31]}}, y_s9}) - $signed({{4{h_q[31]}}, h_q})
				+ $signed({{2{fdy_c[33]}}, fdy_c[33:0]});
			cax_s10 <= cax_s9; cay_s10 <= cay_s9;

			sa_s11  <= lim_mag({{2{cax_s10[33]}}, cax_s10}) * lim_mag({{2{cax_s10[33]}}, cax_s10});
			sb_s11  <= lim_mag({{2{cay_s10[33]}}, cay_s10}) * lim_mag({{2{cay_s10[33]}}, cay_s10});
			sc_s11  <= lim_mag(cbx_s10) * lim_mag(cbx_s10);
			sd_s11  <= lim_mag(cby_s10) * lim_mag(cby_s10);
			neg_s11 <= cbx_s10[35] && cay_s10[33];

			dca_s12 <= sa_s11 + sb_s11;
			dcb_s12 <= sc_s11 + sd_s11;
			neg_s12 <= neg_s11;

			dmin_s13 <= (dca_s12 < dcb_s12) ? dca_s12 : dcb_s12;
			neg_s13  <= neg_s12;

			if (rb_neg) begin
				dist_q <= (rb_root > 32'h80000000) ? 32'h80000000 : 32'd0 - rb_root;
			end else begin
				dist_q <= (rb_root > 32'h7FFFFFFF) ? 32'h7FFFFFFF : rb_root;
			end
		end
	end

	ccd_isqrt #(.SIDE_W(32)) u_root_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_val    (sum_s2),
		.in_side   (y_s2),
		.out_valid (qa_valid),
		.out_root  (qa_root),
		.out_side  (qa_y)
	);

	ccd_isqrt #(.SIDE_W(1)) u_root_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s13),
		.in_val    (dmin_s13),
		.in_side   (neg_s13),
		.out_valid (rb_valid),
		.out_root  (rb_root),
		.out_side  (rb_neg)
	);

	assign out_valid = out_valid_q;
	assign distance  = dist_q;
endmodule
`default_nettype wire

>>> bench/capped_cone_distance_checker.sv
`default_nettype none
module capped_cone_distance_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ccd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ccd_pkg::WORD_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic signed [31:0]            point_x,
	input  wire logic signed [31:0]            point_y,
	input  wire logic signed [31:0]            point_z,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic signed [31:0]            distance,
	output int                                 mismatches,
	output int                                 pending,
	output int                                 words_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import ccd_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FRAC;

	longint r_bot, r_top, h_half, e_dx, e_dy, e_inv;
	logic signed [31:0] dist_q[$];

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] acc, trial;
		acc = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = acc | (64'd1 << b);
			if (trial * trial <= v)
				acc = trial;
		end
		return acc;
	endfunction

	function automatic logic [63:0] clamp_square(input longint v);
		logic [63:0] m;
		m = (v < 0) ? 64'(-v) : 64'(v);
		if (m > (64'd1 << 31))
			m = 64'd1 << 31;
		return m * m;
	endfunction

	function automatic logic signed [31:0] cone_distance(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		longint x, y, z, q, r, cax, cay, t, cbx, cby;
		logic [63:0] ux, uz, dca, dcb, root;
		logic signed [127:0] a1, a2, w_dx, w_dy, w_inv, dd, pp;
		x = px;
		y = py;
		z = pz;
		ux = (x < 0) ? 64'(-x) : 64'(x);
		uz = (z < 0) ? 64'(-z) : 64'(z);
		q = longint'(root_floor(ux * ux + uz * uz));
		r = (y < 0) ? r_bot : r_top;
		cax = q - ((q < r) ? q : r);
		cay = ((y < 0) ? -y : y) - h_half;
		a1 = r_top - q;
		a2 = h_half - y;
		w_dx = e_dx;
		w_dy = e_dy;
		w_inv = e_inv;
		dd = a1 * w_dx + a2 * w_dy;
		if (dd <= 0) begin
			t = 0;
		end else begin
			pp = (dd * w_inv) >>> (2 * FRAC);
			t = (pp >= ONE) ? ONE : longint'(pp[63:0]);
		end
		cbx = q - r_top + ((t * e_dx) >>> FRAC);
		cby = y - h_half + ((t * e_dy) >>> FRAC);
		dca = clamp_square(cax) + clamp_square(cay);
		dcb = clamp_square(cbx) + clamp_square(cby);
		root = root_floor((dca < dcb) ? dca : dcb);
		if (cbx < 0 && cay < 0) begin
			if (root > (64'd1 << 31))
				root = 64'd1 << 31;
			return 32'(-longint'(root));
		end
		if (root > 64'h7FFF_FFFF)
			root = 64'h7FFF_FFFF;
		return 32'(root);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_bot = ONE;
			r_top = 0;
			h_half = ONE;
			e_dx = -ONE;
			e_dy = 2 * ONE;
			e_inv = longint'(EDGE_INV_RESET);
			dist_q.delete();
			mismatches = 0;
			words_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				words_checked++;
				if (dist_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected distance word %0d", distance);
				end else begin
					logic signed [31:0] want;
					want = dist_q.pop_front();
					if (distance !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("distance mismatch: expected %0d got %0d", want, distance);
					end
				end
			end
			if (in_valid && in_ready)
				dist_q.push_back(cone_distance(point_x, point_y, point_z));
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_RADIUS_BOTTOM: r_bot = longint'(signed'(cfg_data));
					CFG_RADIUS_TOP:    r_top = longint'(signed'(cfg_data));
					CFG_HALF_HEIGHT:   h_half = longint'(signed'(cfg_data));
					CFG_EDGE_DX:       e_dx = longint'(signed'(cfg_data));
					CFG_EDGE_DY:       e_dy = longint'(signed'(cfg_data));
					CFG_EDGE_INV:      e_inv = longint'(cfg_data[30:0]);
					default: ;
				endcase
			end
		end
		pending = dist_q.size();
	end
endmodule
`default_nettype wire

>>> bench/tb_capped_cone_distance_top.sv
`default_nettype none
module tb_capped_cone_distance_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ccd_pkg::*;

	localparam int LIMIT = 400000;
	localparam int SETS = 8;
	localparam int PER_SET = 125;

	logic clk, arst_n, cfg_we, in_valid, out_valid, in_ready, out_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0] cfg_data;
	logic signed [31:0] point_x, point_y, point_z, distance;
	int mismatches, pending, words_checked, cycles, send_idle, recv_idle, sent;
	logic took;

	capped_cone_distance_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready), .distance(distance)
	);

	capped_cone_distance_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready), .distance(distance),
		.mismatches(mismatches), .pending(pending), .words_checked(words_checked)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		took <= in_valid && in_ready;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("capped_cone_distance_top verification failed");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle);

	task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		do @(negedge clk); while (!took);
		sent++;
	endtask

	task automatic load_cone(input logic [31:0] rb, input logic [31:0] rt,
			input logic [31:0] hh, input logic [31:0] dx, input logic [31:0] dy,
			input logic [31:0] inv);
		logic [31:0] vals[6];
		vals = '{rb, rt, hh, dx, dy, inv};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic logic [31:0] coord;
		case ($urandom_range(0, 5))
			0:       return $urandom();
			1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
		endcase
	endfunction

	task automatic random_cone;
		longint r1, r2, hh, dx, dy, len, inv;
		r1 = $urandom_range(0, 4 << 16);
		r2 = $urandom_range(0, 4 << 16);
		hh = $urandom_range(1 << 12, 4 << 16);
		dx = r2 - r1;
		dy = 2 * hh;
		len = dx * dx + dy * dy;
		inv = (longint'(1) << 48) / len;
		if (inv > 64'h7FFF_FFFF)
			inv = 64'h7FFF_FFFF;
		load_cone(32'(r1), 32'(r2), 32'(hh), 32'(dx), 32'(dy), 32'(inv));
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		in_valid = 0;
		out_ready = 0;
		point_x = 0;
		point_y = 0;
		point_z = 0;
		cycles = 0;
		sent = 0;
		send_idle = 11;
		recv_idle = 57;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_point(0, 0, 0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'h8000_0000, 0, 0);
		send_point(0, 32'h7FFF_FFFF, 0);
		send_point(0, 32'h8000_0000, 0);
		send_point(32'h0000_4000, 32'h0000_4000, 0);
		send_point(32'h0000_4000, 32'hFFFF_C000, 32'h0000_4000);
		send_point(0, 32'h0001_0000, 0);
		send_point(0, 32'hFFFF_0000, 0);
		send_point(32'h0003_0000, 32'hFFFF_8000, 32'hFFFD_0000);
		send_point(32'h0001_0000, 32'h0000_8000, 0);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);

		for (int s = 0; s < SETS; s++) begin
			drain();
			send_idle = (s < 3) ? 11 : (s < 6) ? 57 : 0;
			recv_idle = (s < 3) ? 57 : (s < 6) ? 11 : 0;
			case (s)
				1: load_cone(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
						32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
				3: load_cone(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
						32'h8000_0000, 32'h8000_0000, 0);
				5: load_cone($urandom(), $urandom(), $urandom(), $urandom(),
						$urandom(), $urandom());
				default: random_cone();
			endcase
			for (int i = 0; i < PER_SET; i++)
				send_point(coord(), coord(), coord());
		end
		drain();

		$display("checked %0d distance words for %0d points over %0d cone settings",
			words_checked, sent, SETS + 1);
		if (mismatches == 0 && pending == 0)
			$display("capped_cone_distance_top verification clean");
		else
			$display("capped_cone_distance_top verification failed");
		$finish;
	end
endmodule
`default_nettype wire

>>> capped_cone_distance_top.f
rtl/ccd_pkg.sv
rtl/ccd_isqrt.sv
rtl/capped_cone_distance_top.sv
bench/capped_cone_distance_checker.sv
bench/tb_capped_cone_distance_top.sv
